// ===== design/erm_pkg.sv =====
package erm_pkg;

  localparam int unsigned ANGLE_BITS_DEF = 16;
  localparam int unsigned FRAC_BITS_DEF  = 14;
  localparam int unsigned OUT_W          = 16;
  localparam int unsigned SERIES_STEPS   = 6;
  localparam logic [63:0] Q30_ONE        = 64'd1 << 30;
  localparam logic [31:0] HALF_PI_Q30    = 32'd1686629713;

  typedef struct packed {
    logic [15:0] angle_x;
    logic [15:0] angle_y;
    logic [15:0] angle_z;
  } erm_in_t;

  typedef struct packed {
    logic signed [15:0] m00;
    logic signed [15:0] m01;
    logic signed [15:0] m02;
    logic signed [15:0] m10;
    logic signed [15:0] m11;
    logic signed [15:0] m12;
    logic signed [15:0] m20;
    logic signed [15:0] m21;
    logic signed [15:0] m22;
  } erm_out_t;

  // series divisor for cell k of the Horner chain
  function automatic logic [7:0] series_div(input int unsigned k);
    logic [7:0] d;
    case (k)
      0: d = 8'd156;
      1: d = 8'd110;
      2: d = 8'd72;
      3: d = 8'd42;
      4: d = 8'd20;
      default: d = 8'd6;
    endcase
    return d;
  endfunction

endpackage

// ===== design/erm_horner_cell.sv =====
// One Horner step: h' = 2^30 - ((z2*h)>>30)/d, for six independent sine lanes.
// Two stages: the z2*h product, then the divide by reciprocal multiply.
module erm_horner_cell #(
  parameter int unsigned DIV = 156
) (
  input  logic        clk_i,
  input  logic [30:0] z_i    [6],
  input  logic [31:0] z2_i   [6],
  input  logic [30:0] h_i    [6],
  input  logic [1:0]  quad_i [6],
  output logic [30:0] z_o    [6],
  output logic [31:0] z2_o   [6],
  output logic [30:0] h_o    [6],
  output logic [1:0]  quad_o [6]
);
  import erm_pkg::*;

  // floor(x/DIV) == (x*RECIP) >> SHIFT for every x below 2^32
  localparam int unsigned SHIFT   = 32 + $clog2(DIV);
  localparam logic [63:0] RECIP_W = ((64'd1 << SHIFT) + 64'(DIV) - 64'd1) / 64'(DIV);
  localparam logic [32:0] RECIP   = RECIP_W[32:0];

  logic [30:0] z_a_q    [6];
  logic [31:0] z2_a_q   [6];
  logic [31:0] x_a_q    [6];
  logic [1:0]  quad_a_q [6];
  logic [30:0] h_d      [6];

  // first half: x = (z2*h) >> 30
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 6; i++) begin
      logic [61:0] p;
      p = 62'(z2_i[i]) * 62'(h_i[i]);
      x_a_q[i] <= p[61:30];
    end
    z_a_q    <= z_i;
    z2_a_q   <= z2_i;
    quad_a_q <= quad_i;
  end

  // second half: h' = 2^30 - x/DIV
  always_comb begin
    for (int i = 0; i < 6; i++) begin
      logic [64:0] r;
      r = 65'(x_a_q[i]) * 65'(RECIP);
      h_d[i] = 31'(Q30_ONE) - 31'(r >> SHIFT);
    end
  end

  always_ff @(posedge clk_i) begin
    z_o    <= z_a_q;
    z2_o   <= z2_a_q;
    h_o    <= h_d;
    quad_o <= quad_a_q;
  end
endmodule

// ===== design/euler_rotation_matrix_core.sv =====
// Channel  | Ports                     | Beat
// ---------+---------------------------+-------------------------------
// command  | start_i, busy_o, in_i     | accepted when start_i & !busy_o
// result   | valid_o, out_o            | no stall
//
// One beat per cycle sustained; busy_o is always low. 20 register stages
// from in_i to out_o: 3 for quadrant fold, z and z^2, 12 in the Horner
// chain (6 cells of 2 stages), 1 sine finish, 1 for t1/t2 and the direct
// products, 1 for the products with t1/t2, 1 sum and clamp, 1 output.
// Reset clears only the valid pipeline; the receiver cannot stall.
module euler_rotation_matrix_core #(
  parameter int unsigned ANGLE_BITS = erm_pkg::ANGLE_BITS_DEF,
  parameter int unsigned FRAC_BITS  = erm_pkg::FRAC_BITS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  erm_pkg::erm_in_t in_i,
  output logic             busy_o,
  output logic             valid_o,
  output erm_pkg::erm_out_t out_o
);
  import erm_pkg::*;

  localparam int unsigned LAT = 20;
  localparam int unsigned FW  = FRAC_BITS + 2;   // signed width holding +-one
  localparam logic [ANGLE_BITS-1:0] QUARTER = (ANGLE_BITS)'(1) << (ANGLE_BITS - 2);

  logic [LAT-1:0] vld_q;
  assign busy_o  = 1'b0;
  assign valid_o = vld_q[LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[LAT-2:0], start_i};
    end
  end

  // stage 1: six lanes (sin x, cos x, sin y, cos y, sin z, cos z) -> t in Q30
  // bits above ANGLE_BITS are dropped, narrow fields are zero extended
  logic [ANGLE_BITS-1:0] ang [6];
  assign ang[0] = (ANGLE_BITS)'(in_i.angle_x);
  assign ang[2] = (ANGLE_BITS)'(in_i.angle_y);
  assign ang[4] = (ANGLE_BITS)'(in_i.angle_z);
  assign ang[1] = ang[0] + QUARTER;
  assign ang[3] = ang[2] + QUARTER;
  assign ang[5] = ang[4] + QUARTER;

  logic [31:0] t_q    [6];
  logic [1:0]  quad1_q [6];
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 6; i++) begin
      logic [ANGLE_BITS-1:0] r;
      r = {2'b00, ang[i][ANGLE_BITS-3:0]};
      if (ang[i][ANGLE_BITS-2]) r = QUARTER - r;
      t_q[i]     <= 32'(r) << (32 - ANGLE_BITS);
      quad1_q[i] <= ang[i][ANGLE_BITS-1:ANGLE_BITS-2];
    end
  end

  // stage 2: z = t*pi/2
  logic [30:0] z_q [6];
  logic [1:0]  quad2_q [6];
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 6; i++) begin
      logic [63:0] p;
      p = {32'd0, t_q[i]} * {32'd0, HALF_PI_Q30};
      z_q[i]     <= p[60:30];
      quad2_q[i] <= quad1_q[i];
    end
  end

  // stage 3: z^2, up to about 2.47 in Q30 so it takes 32 bits
  logic [30:0] z3_q    [6];
  logic [31:0] z23_q   [6];
  logic [1:0]  quad3_q [6];
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 6; i++) begin
      logic [61:0] p;
      p = {31'd0, z_q[i]} * {31'd0, z_q[i]};
      z3_q[i]    <= z_q[i];
      z23_q[i]   <= p[61:30];
      quad3_q[i] <= quad2_q[i];
    end
  end

  logic [30:0] cz_q  [7][6];
  logic [31:0] cz2_q [7][6];
  logic [30:0] ch_q  [7][6];
  logic [1:0]  cq_q  [7][6];
  assign cz_q[0]  = z3_q;
  assign cz2_q[0] = z23_q;
  assign ch_q[0]  = '{default: 31'(Q30_ONE)};
  assign cq_q[0]  = quad3_q;

  // Horner chain: one cell per series term
  for (genvar k = 0; k < SERIES_STEPS; k++) begin : g_cell
    erm_horner_cell #(.DIV(int'(series_div(k)))) u_cell (
      .clk_i  (clk_i),
      .z_i    (cz_q[k]),
      .z2_i   (cz2_q[k]),
      .h_i    (ch_q[k]),
      .quad_i (cq_q[k]),
      .z_o    (cz_q[k+1]),
      .z2_o   (cz2_q[k+1]),
      .h_o    (ch_q[k+1]),
      .quad_o (cq_q[k+1])
    );
  end

  // sine finish: s = z*h, round, limit, sign
  logic signed [FW-1:0] sc_q [6];
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 6; i++) begin
      logic [61:0] p;
      logic [31:0] s;
      logic [FW-1:0] m;
      p = {31'd0, cz_q[SERIES_STEPS][i]} * {31'd0, ch_q[SERIES_STEPS][i]};
      s = {1'b0, p[60:30]};
      if (FRAC_BITS < 30) s = (s + (32'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
      if (s > (32'd1 << FRAC_BITS)) s = 32'd1 << FRAC_BITS;
      m = s[FW-1:0];
      sc_q[i] <= cq_q[SERIES_STEPS][i][1] ? -$signed(m) : $signed(m);
    end
  end

  function automatic logic signed [FW+1:0] fmul(input logic signed [FW+1:0] a,
                                                 input logic signed [FW+1:0] b);
    logic signed [2*FW+3:0] p;
    p = a * b + ((2*FW+4)'(1) << (FRAC_BITS - 1));
    return (FW+2)'(p >>> FRAC_BITS);
  endfunction

  function automatic logic signed [15:0] to_field(input logic signed [FW+2:0] v);
    logic signed [FW+2:0] one;
    one = (FW+3)'(1) << FRAC_BITS;
    if (v > one) v = one;
    if (v < -one) v = -one;
    return 16'(v);
  endfunction

  // product stage A: t1, t2 plus the direct products
  logic signed [FW+1:0] sx_a, cx_a, sy_a, cy_a, sz_a, cz_a;
  assign sx_a = (FW+2)'(sc_q[0]);
  assign cx_a = (FW+2)'(sc_q[1]);
  assign sy_a = (FW+2)'(sc_q[2]);
  assign cy_a = (FW+2)'(sc_q[3]);
  assign sz_a = (FW+2)'(sc_q[4]);
  assign cz_a = (FW+2)'(sc_q[5]);

  logic signed [FW+1:0] t1_q, t2_q, sx_b, cx_b, sy_b, p00_q, p10_q, p21_q, p22_q;
  logic signed [FW+1:0] szcx_q, szsx_q, czcx_q, czsx_q;
  always_ff @(posedge clk_i) begin
    t1_q   <= fmul(sy_a, cz_a);
    t2_q   <= fmul(sy_a, sz_a);
    p00_q  <= fmul(cz_a, cy_a);
    p10_q  <= -fmul(sz_a, cy_a);
    p21_q  <= -fmul(sx_a, cy_a);
    p22_q  <= fmul(cx_a, cy_a);
    szcx_q <= fmul(sz_a, cx_a);
    szsx_q <= fmul(sz_a, sx_a);
    czcx_q <= fmul(cz_a, cx_a);
    czsx_q <= fmul(cz_a, sx_a);
    sx_b   <= sx_a;
    cx_b   <= cx_a;
    sy_b   <= sy_a;
  end

  // product stage B: products with t1/t2
  logic signed [FW+1:0] a1_q, a2_q, a4_q, a5_q, b1_q, b2_q, b4_q, b5_q;
  logic signed [FW+1:0] p00_c, p10_c, p21_c, p22_c, sy_c;
  always_ff @(posedge clk_i) begin
    a1_q <= szcx_q; b1_q <= fmul(t1_q, sx_b);
    a2_q <= szsx_q; b2_q <= fmul(t1_q, cx_b);
    a4_q <= czcx_q; b4_q <= fmul(t2_q, sx_b);
    a5_q <= czsx_q; b5_q <= fmul(t2_q, cx_b);
    p00_c <= p00_q; p10_c <= p10_q; p21_c <= p21_q; p22_c <= p22_q; sy_c <= sy_b;
  end

  // sum and clamp stage
  erm_out_t res_q;
  always_ff @(posedge clk_i) begin
    res_q.m00 <= to_field((FW+3)'(p00_c));
    res_q.m01 <= to_field((FW+3)'(a1_q) + (FW+3)'(b1_q));
    res_q.m02 <= to_field((FW+3)'(a2_q) - (FW+3)'(b2_q));
    res_q.m10 <= to_field((FW+3)'(p10_c));
    res_q.m11 <= to_field((FW+3)'(a4_q) - (FW+3)'(b4_q));
    res_q.m12 <= to_field((FW+3)'(a5_q) + (FW+3)'(b5_q));
    res_q.m20 <= to_field((FW+3)'(sy_c));
    res_q.m21 <= to_field((FW+3)'(p21_c));
    res_q.m22 <= to_field((FW+3)'(p22_c));
  end

  // output register
  always_ff @(posedge clk_i) begin
    out_o <= res_q;
  end
endmodule
